>>> sv/cdds_pkg.sv
// ----------------------------------------------------------------------------
// cdds_pkg: shared types, constants and calendar functions
// Widths of the date fields, the reset date and the month and leap-year
// helpers used by the day stepper and its load path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdds_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int YEAR_MAX    = 9999;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int YDAY_W  = 9;
   localparam int YY_W    = 7;

   localparam int YEAR_BIAS   = 1900;
   localparam int DAYS_LEAP   = 366;
   localparam int DAYS_COMMON = 365;
   localparam int MONTHS      = 12;
   localparam int LAST_DAY    = 31;
   localparam int LAST_YY     = 99;
   localparam int HUNDRED     = 100;

   // Year / 100 is taken as (year * RECIP_100) >> RECIP_SHIFT, exact below 43699.
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = $clog2(RECIP_100 + 1);
   localparam int CENT_W      = YEAR_W + RECIP_W - RECIP_SHIFT;

   localparam int RESET_YEAR = (YEAR_MAX < 1970) ? YEAR_MAX : 1970;
   localparam int RESET_YY   = RESET_YEAR % 100;
   localparam int RESET_CC   = (RESET_YEAR / 100) % 4;

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(MONTHS);

   // The date carries year mod 100 and century mod 4 next to the year so
   // that the leap-year test needs no division.
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [YDAY_W-1:0]  yday;
      logic [YY_W-1:0]    yy;
      logic [1:0]         cc;
   } date_type;

   localparam date_type RESET_DATE = '{
      year:  YEAR_W'(RESET_YEAR),
      month: MONTH_JAN,
      day:   DAY_W'(1),
      yday:  YDAY_W'(1),
      yy:    YY_W'(RESET_YY),
      cc:    2'(RESET_CC)
   };

   function automatic logic is_leap(input logic [1:0] year_lo, input logic [YY_W-1:0] yy,
                                    input logic [1:0] cc);
      return (year_lo == 2'd0) && ((yy != '0) || (cc == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_W'(30);
         MONTH_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
         default:   len = DAY_W'(LAST_DAY);
      endcase
      return len;
   endfunction

   function automatic logic [YDAY_W-1:0] year_len(input logic leap);
      return leap ? YDAY_W'(DAYS_LEAP) : YDAY_W'(DAYS_COMMON);
   endfunction

endpackage

`default_nettype wire

>>> sv/cdds_req_if.sv
// ----------------------------------------------------------------------------
// cdds_req_if: request channel
// Valid/ready channel that carries one load or shift word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdds_req_if
   import cdds_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic signed [YEAR_W-1:0]      load_year_bias;
   logic [MONTH_W-1:0]            load_month_index;
   logic [DAY_W-1:0]              load_day;
   logic [YDAY_W-1:0]             load_yday_index;
   logic signed [OFFSET_BITS-1:0] offset;

   modport source (output valid, mode, load_year_bias, load_month_index, load_day,
                   load_yday_index, offset, input ready);
   modport sink (input valid, mode, load_year_bias, load_month_index, load_day,
                 load_yday_index, offset, output ready);
endinterface

`default_nettype wire

>>> sv/cdds_rsp_if.sv
// ----------------------------------------------------------------------------
// cdds_rsp_if: response channel
// Valid/ready channel that carries the date word after each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdds_rsp_if
   import cdds_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  year;
   logic [MONTH_W-1:0] month;
   logic [DAY_W-1:0]   day;
   logic [YDAY_W-1:0]  ordinal_day;
   logic               range_error;

   modport source (output valid, year, month, day, ordinal_day, range_error, input ready);
   modport sink (input valid, year, month, day, ordinal_day, range_error, output ready);
endinterface

`default_nettype wire

>>> sv/cdds_step_unit.sv
// ----------------------------------------------------------------------------
// cdds_step_unit: one-day date step
// Moves a date one day forward or back and flags when the date already
// sits on the bound for that direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdds_step_unit
   import cdds_pkg::*;
(
   input  date_type cur,
   input  logic     back,
   output date_type nxt,
   output logic     at_bound
);

   always_comb begin
      logic               leap_cur;
      logic               leap_prev;
      logic [DAY_W-1:0]   mlen;
      logic [MONTH_W-1:0] prev_month;
      logic [YEAR_W-1:0]  prev_year;
      logic [YY_W-1:0]    prev_yy;
      logic [1:0]         prev_cc;

      leap_cur   = is_leap(cur.year[1:0], cur.yy, cur.cc);
      prev_year  = cur.year - 1'b1;
      prev_yy    = (cur.yy == '0) ? YY_W'(LAST_YY) : cur.yy - 1'b1;
      prev_cc    = (cur.yy == '0) ? cur.cc - 1'b1 : cur.cc;
      leap_prev  = is_leap(prev_year[1:0], prev_yy, prev_cc);
      prev_month = cur.month - 1'b1;
      mlen       = month_len(cur.month, leap_cur);
      nxt        = cur;

      if (back) begin
         at_bound = (cur.year == '0) && (cur.month == MONTH_JAN) && (cur.day == DAY_W'(1));
         if (cur.yday > YDAY_W'(1)) begin
            nxt.yday = cur.yday - 1'b1;
         end
         if (cur.day > DAY_W'(1)) begin
            nxt.day = cur.day - 1'b1;
         end else if (cur.month > MONTH_JAN) begin
            nxt.month = prev_month;
            nxt.day   = month_len(prev_month, leap_cur);
         end else begin
            nxt.year  = prev_year;
            nxt.yy    = prev_yy;
            nxt.cc    = prev_cc;
            nxt.month = MONTH_DEC;
            nxt.day   = DAY_W'(LAST_DAY);
            nxt.yday  = year_len(leap_prev);
         end
      end else begin
         at_bound = (cur.year >= YEAR_W'(YEAR_MAX)) && (cur.month == MONTH_DEC) &&
                    (cur.day == DAY_W'(LAST_DAY));
         if (cur.yday < YDAY_W'(DAYS_LEAP)) begin
            nxt.yday = cur.yday + 1'b1;
         end
         if (cur.day >= mlen) begin
            if (cur.month >= MONTH_DEC) begin
               nxt.year  = cur.year + 1'b1;
               nxt.month = MONTH_JAN;
               nxt.yday  = YDAY_W'(1);
               nxt.yy    = (cur.yy == YY_W'(LAST_YY)) ? '0 : cur.yy + 1'b1;
               nxt.cc    = (cur.yy == YY_W'(LAST_YY)) ? cur.cc + 1'b1 : cur.cc;
            end else begin
               nxt.month = cur.month + 1'b1;
            end
            nxt.day = DAY_W'(1);
         end else begin
            nxt.day = cur.day + 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> sv/calendar_date_day_stepper.sv
// ----------------------------------------------------------------------------
// calendar_date_day_stepper: Gregorian date counter
// Holds a calendar date that is loaded from broken-down time fields or
// moved by a signed number of days, one day per clock.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one word at a time. With mode low the word loads
//   the date (year minus 1900, zero-based month, day, zero-based day of
//   year); out-of-range fields saturate. With mode high the date moves by
//   the signed offset. Every request produces one rsp word with the date
//   afterwards and range_error, which is set when a shift stopped at
//   0000-01-01 or at December 31 of the last year.
//   A load passes through S_DIV, S_REM, S_FIX and S_OUT before rsp valid; a
//   shift stays in S_STEP until |offset| days are done or a bound is hit, then
//   S_OUT. The single day-step unit advances the date once per cycle in S_STEP.
//   req.ready is high only while no request is in progress; one request is
//   worked at a time. A finished word waits in the rsp register while the
//   next request is already accepted; a stalled receiver holds the core in
//   its final state until the register frees.
//   Reset (synchronous, active high) sets the date to 1970-01-01, day of
//   year 1, and empties the rsp register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_day_stepper
   import cdds_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   cdds_req_if.sink    req,
   cdds_rsp_if.source  rsp
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_REM,
      S_FIX,
      S_STEP,
      S_OUT
   } state_type;

   state_type              state_ff, state_in;
   date_type               date_ff, date_in;
   logic                   back_ff, back_in;
   logic [OFFSET_BITS-1:0] cnt_ff, cnt_in;
   logic                   err_ff, err_in;
   logic [MONTH_W-1:0]     ld_month_ff, ld_month_in;
   logic [DAY_W-1:0]       ld_day_ff, ld_day_in;
   logic [YDAY_W:0]        ld_yday_ff, ld_yday_in;
   logic [CENT_W-1:0]      cent_ff, cent_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [YEAR_W-1:0]      rsp_year_ff, rsp_year_in;
   logic [MONTH_W-1:0]     rsp_month_ff, rsp_month_in;
   logic [DAY_W-1:0]       rsp_day_ff, rsp_day_in;
   logic [YDAY_W-1:0]      rsp_yday_ff, rsp_yday_in;
   logic                   rsp_err_ff, rsp_err_in;

   date_type step_nxt;
   logic     step_at_bound;

   cdds_step_unit u_step (
      .cur      (date_ff),
      .back     (back_ff),
      .nxt      (step_nxt),
      .at_bound (step_at_bound)
   );

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.year        = rsp_year_ff;
   assign rsp.month       = rsp_month_ff;
   assign rsp.day         = rsp_day_ff;
   assign rsp.ordinal_day = rsp_yday_ff;
   assign rsp.range_error = rsp_err_ff;

   always_comb begin
      logic signed [YEAR_W+1:0]      year_sum;
      logic [OFFSET_BITS-1:0]        off_u;
      logic [YEAR_W+RECIP_W-1:0]     prod;
      logic [YEAR_W-1:0]             hund;
      logic                          leap;
      logic [DAY_W-1:0]              dim;
      logic [YDAY_W-1:0]             diy;

      year_sum = (YEAR_W+2)'(req.load_year_bias) + (YEAR_W+2)'(YEAR_BIAS);
      off_u    = OFFSET_BITS'(unsigned'(req.offset));
      prod     = (YEAR_W+RECIP_W)'(date_ff.year) * (YEAR_W+RECIP_W)'(RECIP_100);
      hund     = YEAR_W'(cent_ff) * YEAR_W'(HUNDRED);
      leap     = is_leap(date_ff.year[1:0], date_ff.yy, date_ff.cc);
      dim      = month_len(ld_month_ff, leap);
      diy      = year_len(leap);

      state_in     = state_ff;
      date_in      = date_ff;
      back_in      = back_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      ld_month_in  = ld_month_ff;
      ld_day_in    = ld_day_ff;
      ld_yday_in   = ld_yday_ff;
      cent_in      = cent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_year_in  = rsp_year_ff;
      rsp_month_in = rsp_month_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_yday_in  = rsp_yday_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               err_in = 1'b0;
               if (!req.mode) begin
                  if (year_sum < 0) begin
                     date_in.year = '0;
                  end else if (year_sum > (YEAR_W+2)'(YEAR_MAX)) begin
                     date_in.year = YEAR_W'(YEAR_MAX);
                  end else begin
                     date_in.year = year_sum[YEAR_W-1:0];
                  end
                  ld_month_in = (req.load_month_index >= MONTH_DEC) ? MONTH_DEC :
                                req.load_month_index + 1'b1;
                  ld_day_in   = req.load_day;
                  ld_yday_in  = {1'b0, req.load_yday_index} + 1'b1;
                  state_in    = S_DIV;
               end else begin
                  back_in  = req.offset[OFFSET_BITS-1];
                  cnt_in   = back_in ? (~off_u + 1'b1) : off_u;
                  state_in = S_STEP;
               end
            end
         end
         S_DIV: begin
            cent_in  = prod[RECIP_SHIFT +: CENT_W];
            state_in = S_REM;
         end
         S_REM: begin
            date_in.yy = YY_W'(date_ff.year - hund);
            date_in.cc = cent_ff[1:0];
            state_in   = S_FIX;
         end
         S_FIX: begin
            date_in.month = ld_month_ff;
            if (ld_day_ff == '0) begin
               date_in.day = DAY_W'(1);
            end else if (ld_day_ff > dim) begin
               date_in.day = dim;
            end else begin
               date_in.day = ld_day_ff;
            end
            date_in.yday = (ld_yday_ff > {1'b0, diy}) ? diy : ld_yday_ff[YDAY_W-1:0];
            state_in     = S_OUT;
         end
         S_STEP: begin
            if (cnt_ff == '0) begin
               state_in = S_OUT;
            end else if (step_at_bound) begin
               // Remaining days are dropped once the range bound is hit.
               err_in   = 1'b1;
               state_in = S_OUT;
            end else begin
               date_in = step_nxt;
               cnt_in  = cnt_ff - 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_year_in  = date_ff.year;
               rsp_month_in = date_ff.month;
               rsp_day_in   = date_ff.day;
               rsp_yday_in  = date_ff.yday;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         date_ff      <= RESET_DATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         date_ff      <= date_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      back_ff      <= back_in;
      cnt_ff       <= cnt_in;
      err_ff       <= err_in;
      ld_month_ff  <= ld_month_in;
      ld_day_ff    <= ld_day_in;
      ld_yday_ff   <= ld_yday_in;
      cent_ff      <= cent_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_yday_ff  <= rsp_yday_in;
      rsp_err_ff   <= rsp_err_in;
   end

endmodule

`default_nettype wire

>>> sv/cdds_checker.sv
// ----------------------------------------------------------------------------
// cdds_checker: port-level assertions for the date stepper
// Watches the request and response ports of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdds_checker
   import cdds_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [YEAR_W-1:0]  rsp_year,
   input wire logic [MONTH_W-1:0] rsp_month,
   input wire logic [DAY_W-1:0]   rsp_day,
   input wire logic [YDAY_W-1:0]  rsp_ordinal_day,
   input wire logic               rsp_range_error
);

   // A response word held by the receiver must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_year) && $stable(rsp_month) &&
      $stable(rsp_day) && $stable(rsp_ordinal_day) && $stable(rsp_range_error))
      else $error("rsp word changed while stalled");

   // Only one request is worked at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_date_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month >= MONTH_JAN && rsp_month <= MONTH_DEC &&
      rsp_day >= DAY_W'(1) && rsp_day <= DAY_W'(LAST_DAY) &&
      rsp_ordinal_day >= YDAY_W'(1) && rsp_ordinal_day <= YDAY_W'(DAYS_LEAP) &&
      rsp_year <= YEAR_W'(YEAR_MAX))
      else $error("rsp date field out of range");

   // A range error is only reported with the date parked on a bound.
   a_err_at_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |->
      (rsp_year == '0 && rsp_month == MONTH_JAN && rsp_day == DAY_W'(1)) ||
      (rsp_year == YEAR_W'(YEAR_MAX) && rsp_month == MONTH_DEC &&
       rsp_day == DAY_W'(LAST_DAY)))
      else $error("range error away from a bound");

endmodule

bind calendar_date_day_stepper cdds_checker u_cdds_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_year        (rsp.year),
   .rsp_month       (rsp.month),
   .rsp_day         (rsp.day),
   .rsp_ordinal_day (rsp.ordinal_day),
   .rsp_range_error (rsp.range_error)
);

`default_nettype wire
